@@ rtl/hrpm_pkg.sv @@
// Shared types and constants for the HSV range pixel mask unit.
// No dependencies; every other file in rtl/ imports this package.
package hrpm_pkg;

    // Channel and angle constants.
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned HUE_W     = 9;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_NONE  = 9'd0;

    // Hue numerator and bound products: 511 * 255 fits in 17 bits.
    localparam int unsigned HPROD_W = 17;
    // Saturation products: 255 * 255 fits in 16 bits.
    localparam int unsigned SPROD_W = 16;

    // Register map, indexed by paddr[4:2].
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_HUE_LOW  = 3'd0;
    localparam logic [2:0] REG_HUE_HIGH = 3'd1;
    localparam logic [2:0] REG_SAT_LOW  = 3'd2;
    localparam logic [2:0] REG_SAT_HIGH = 3'd3;
    localparam logic [2:0] REG_VAL_LOW  = 3'd4;
    localparam logic [2:0] REG_VAL_HIGH = 3'd5;

    // Which channel holds the maximum; red wins ties, then green.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Threshold register bundle.
    typedef struct packed {
        logic [HUE_W-1:0]  hue_low;
        logic [HUE_W-1:0]  hue_high;
        logic [CHAN_W-1:0] sat_low;
        logic [CHAN_W-1:0] sat_high;
        logic [CHAN_W-1:0] val_low;
        logic [CHAN_W-1:0] val_high;
    } hrpm_cfg_t;

    // One BGR pixel.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // Word held after the min/max stage.
    typedef struct packed {
        pixel_t             pix;
        logic [CHAN_W-1:0]  mx;
        logic [CHAN_W-1:0]  d;
        sector_t            sector;
        logic signed [CHAN_W:0] diff;
    } s1_word_t;

    // Word held after the product stage.
    typedef struct packed {
        pixel_t             pix;
        logic [HPROD_W-1:0] hue_num;
        logic [HPROD_W-1:0] hue_lo_d;
        logic [HPROD_W-1:0] hue_hi_d;
        logic [SPROD_W-1:0] sat_num;
        logic [SPROD_W-1:0] sat_lo_m;
        logic [SPROD_W-1:0] sat_hi_m;
        logic               d_zero;
        logic               mx_zero;
        logic               val_ok;
    } s2_word_t;

    // Result word.
    typedef struct packed {
        pixel_t pix;
        logic   kept;
    } res_word_t;

endpackage

@@ rtl/hrpm_cfg.sv @@
// APB-style threshold register file of the HSV range pixel mask unit.
// Depends on hrpm_pkg for the register map and the bundle type.
module hrpm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hrpm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output hrpm_pkg::hrpm_cfg_t         cfg
);
    import hrpm_pkg::*;

    hrpm_cfg_t  cfg_reg;
    hrpm_cfg_t  cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Decode a completed write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_HUE_LOW:  cfg_next.hue_low  = pwdata[HUE_W-1:0];
                REG_HUE_HIGH: cfg_next.hue_high = pwdata[HUE_W-1:0];
                REG_SAT_LOW:  cfg_next.sat_low  = pwdata[CHAN_W-1:0];
                REG_SAT_HIGH: cfg_next.sat_high = pwdata[CHAN_W-1:0];
                REG_VAL_LOW:  cfg_next.val_low  = pwdata[CHAN_W-1:0];
                REG_VAL_HIGH: cfg_next.val_high = pwdata[CHAN_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Reset values accept every pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low  <= HUE_NONE;
            cfg_reg.hue_high <= HUE_FULL;
            cfg_reg.sat_low  <= '0;
            cfg_reg.sat_high <= CHAN_MAX;
            cfg_reg.val_low  <= '0;
            cfg_reg.val_high <= CHAN_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (reg_idx)
            REG_HUE_LOW:  prdata = 32'(cfg_reg.hue_low);
            REG_HUE_HIGH: prdata = 32'(cfg_reg.hue_high);
            REG_SAT_LOW:  prdata = 32'(cfg_reg.sat_low);
            REG_SAT_HIGH: prdata = 32'(cfg_reg.sat_high);
            REG_VAL_LOW:  prdata = 32'(cfg_reg.val_low);
            REG_VAL_HIGH: prdata = 32'(cfg_reg.val_high);
            default:      prdata = '0;
        endcase
    end

endmodule

@@ rtl/hrpm_minmax.sv @@
// Stage 1: channel maximum, spread, hue sector and signed channel difference.
// Depends on hrpm_pkg for pixel and stage word types.
module hrpm_minmax (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hrpm_pkg::pixel_t    in_pix,
    output logic                out_valid,
    input  logic                out_ready,
    output hrpm_pkg::s1_word_t  out_word
);
    import hrpm_pkg::*;

    logic              valid_reg;
    s1_word_t          word_reg;
    s1_word_t          word_next;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;

    // The stage takes a word when it is empty or its word moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // Max, min and sector; red is tested first, then green.
    always_comb
    begin
        mx = in_pix.blue;
        mn = in_pix.blue;
        if (in_pix.green > mx) mx = in_pix.green;
        if (in_pix.red > mx)   mx = in_pix.red;
        if (in_pix.green < mn) mn = in_pix.green;
        if (in_pix.red < mn)   mn = in_pix.red;

        word_next.pix = in_pix;
        word_next.mx  = mx;
        word_next.d   = mx - mn;
        if (in_pix.red == mx)
        begin
            word_next.sector = SEC_RED;
            word_next.diff   = $signed({1'b0, in_pix.green}) - $signed({1'b0, in_pix.blue});
        end
        else if (in_pix.green == mx)
        begin
            word_next.sector = SEC_GREEN;
            word_next.diff   = $signed({1'b0, in_pix.blue}) - $signed({1'b0, in_pix.red});
        end
        else
        begin
            word_next.sector = SEC_BLUE;
            word_next.diff   = $signed({1'b0, in_pix.red}) - $signed({1'b0, in_pix.green});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ rtl/hrpm_product.sv @@
// Stage 2: hue numerator and the cross-multiplied bounds for hue and saturation.
// Depends on hrpm_pkg for stage word types and the threshold bundle.
module hrpm_product (
    input  logic                clk,
    input  logic                rst_n,
    input  hrpm_pkg::hrpm_cfg_t cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  hrpm_pkg::s1_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output hrpm_pkg::s2_word_t  out_word
);
    import hrpm_pkg::*;

    logic                   valid_reg;
    s2_word_t               word_reg;
    s2_word_t               word_next;
    logic [HUE_W-1:0]       offs;
    logic [HPROD_W-1:0]     base;
    logic signed [HPROD_W:0] term;
    logic signed [HPROD_W:0] hsum;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // Sector offset; a negative red-sector hue wraps by a full turn.
    always_comb
    begin
        case (in_word.sector)
            SEC_RED:   offs = in_word.diff[CHAN_W] ? HUE_FULL : HUE_NONE;
            SEC_GREEN: offs = HUE_GREEN;
            SEC_BLUE:  offs = HUE_BLUE;
            default:   offs = HUE_NONE;
        endcase
    end

    // Hue numerator is offs*d + 60*diff, never negative after the wrap.
    always_comb
    begin
        base = HPROD_W'(offs) * HPROD_W'(in_word.d);
        term = (HPROD_W+1)'(in_word.diff) * 18'sd60;
        hsum = $signed({1'b0, base}) + term;

        word_next.pix      = in_word.pix;
        word_next.hue_num  = hsum[HPROD_W-1:0];
        word_next.hue_lo_d = HPROD_W'(cfg.hue_low) * HPROD_W'(in_word.d);
        word_next.hue_hi_d = HPROD_W'(cfg.hue_high) * HPROD_W'(in_word.d);
        word_next.sat_num  = SPROD_W'(CHAN_MAX) * SPROD_W'(in_word.d);
        word_next.sat_lo_m = SPROD_W'(cfg.sat_low) * SPROD_W'(in_word.mx);
        word_next.sat_hi_m = SPROD_W'(cfg.sat_high) * SPROD_W'(in_word.mx);
        word_next.d_zero   = (in_word.d == '0);
        word_next.mx_zero  = (in_word.mx == '0);
        word_next.val_ok   = (cfg.val_low <= in_word.mx) && (in_word.mx <= cfg.val_high);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ rtl/hrpm_judge.sv @@
// Stage 3: range compares, keep decision and the output register.
// Depends on hrpm_pkg for stage word types and the threshold bundle.
module hrpm_judge (
    input  logic                clk,
    input  logic                rst_n,
    input  hrpm_pkg::hrpm_cfg_t cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  hrpm_pkg::s2_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output hrpm_pkg::res_word_t out_word
);
    import hrpm_pkg::*;

    logic      valid_reg;
    res_word_t word_reg;
    res_word_t word_next;
    logic      hue_ok;
    logic      sat_ok;
    logic      keep;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // A gray pixel has hue 0 and a black pixel has saturation 0.
    always_comb
    begin
        if (in_word.d_zero)
            hue_ok = (cfg.hue_low == HUE_NONE);
        else
            hue_ok = (in_word.hue_lo_d <= in_word.hue_num)
                  && (in_word.hue_num <= in_word.hue_hi_d);

        if (in_word.mx_zero)
            sat_ok = (cfg.sat_low == '0);
        else
            sat_ok = (in_word.sat_lo_m <= in_word.sat_num)
                  && (in_word.sat_num <= in_word.sat_hi_m);

        keep = hue_ok && sat_ok && in_word.val_ok;

        word_next.kept = keep;
        word_next.pix  = keep ? in_word.pix : {CHAN_MAX, CHAN_MAX, CHAN_MAX};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ rtl/hsv_range_pixel_mask_unit.sv @@
// Top level of the HSV range pixel mask unit: register file and three pipeline stages.
// Depends on hrpm_pkg, hrpm_cfg, hrpm_minmax, hrpm_product and hrpm_judge.
//
//  Channel    Direction  Payload
//  s_axis     in         tdata = {red, green, blue}, blue in the low byte
//  m_axis     out        tdata = {out_red, out_green, out_blue}; tuser = kept
//  apb        in/out     six threshold registers at byte addresses 0x00..0x14
//
// One pixel enters per clock while m_axis does not stall; each pixel taken passes
// through the min/max, product and compare stage registers in turn before it leaves.
// Reset clears the stage valid bits and loads thresholds that keep every pixel.
// A stage takes a new word whenever it is empty or its word moves on, so a stall
// on m_axis backs up one stage at a time and bubbles close up.
module hsv_range_pixel_mask_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,   // blue, green, red
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // out_blue, out_green, out_red
    output logic                        m_axis_tuser,   // kept
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hrpm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hrpm_pkg::*;

    hrpm_cfg_t cfg;
    pixel_t    in_pix;
    s1_word_t  s1_word;
    s2_word_t  s2_word;
    res_word_t res_word;
    logic      s1_valid;
    logic      s1_ready;
    logic      s2_valid;
    logic      s2_ready;

    assign in_pix.blue  = s_axis_tdata[7:0];
    assign in_pix.green = s_axis_tdata[15:8];
    assign in_pix.red   = s_axis_tdata[23:16];

    // Threshold registers.
    hrpm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 1: max, spread and sector.
    hrpm_minmax u_minmax (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (in_pix),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_word  (s1_word)
    );

    // Stage 2: products.
    hrpm_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_word   (s1_word),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_word  (s2_word)
    );

    // Stage 3: compares and output register.
    hrpm_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_word   (s2_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (res_word)
    );

    assign m_axis_tdata = {res_word.pix.red, res_word.pix.green, res_word.pix.blue};
    assign m_axis_tuser = res_word.kept;

    // A rejected pixel always comes out white.
    a_reject_white: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 24'hFF_FFFF))
        else $error("rejected pixel is not white");

    // With the output register empty the whole pipeline can take a word.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // Inverted bounds keep nothing.
    a_inverted_none: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            ((cfg.hue_low <= cfg.hue_high) && (cfg.sat_low <= cfg.sat_high)
             && (cfg.val_low <= cfg.val_high)))
        else $error("pixel kept under inverted bounds");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for hsv_range_pixel_mask_unit: random and corner BGR pixels
// go through the stream port under several threshold settings. Needs rtl/hrpm_pkg.sv.
module tb;
    import hrpm_pkg::*;

    // The pipeline holds a pixel in its min/max, product and compare stage registers after it is taken.
    localparam int unsigned PIPE_DEPTH = 3;
    localparam int unsigned HUE_TOP    = (1 << HUE_W) - 1;

    // Addresses past the register map; a write there must change nothing.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam logic [2:0] REG_ORDER [0:5] = '{REG_HUE_LOW, REG_HUE_HIGH, REG_SAT_LOW,
                                               REG_SAT_HIGH, REG_VAL_LOW, REG_VAL_HIGH};

    // Corner pixels, written as {red, green, blue}.
    localparam logic [23:0] CORNER_PIXELS [0:19] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'hFF0001,
        24'h010000, 24'h0100FF, 24'h7F3F00, 24'h00017F, 24'hFE01FF,
        24'h010101, 24'hFF0100, 24'h00FFFE, 24'h123456, 24'hA5C3E7
    };

    typedef enum int {
        BOUNDS_RESET,
        BOUNDS_BAND,
        BOUNDS_EXTREME,
        BOUNDS_RAW,
        BOUNDS_INVERTED
    } bounds_mode_t;

    // Keeps its own copy of the thresholds and the pixels still owed by the block.
    class mask_scoreboard;
        hrpm_cfg_t   bounds;
        res_word_t   owed_pixels[$];
        int unsigned checked;
        int unsigned kept_seen;
        int unsigned mismatches;

        function new();
            bounds.hue_low  = '0;
            bounds.hue_high = HUE_FULL;
            bounds.sat_low  = '0;
            bounds.sat_high = CHAN_MAX;
            bounds.val_low  = '0;
            bounds.val_high = CHAN_MAX;
            checked    = 0;
            kept_seen  = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_HUE_LOW:  bounds.hue_low  = value[HUE_W-1:0];
                REG_HUE_HIGH: bounds.hue_high = value[HUE_W-1:0];
                REG_SAT_LOW:  bounds.sat_low  = value[CHAN_W-1:0];
                REG_SAT_HIGH: bounds.sat_high = value[CHAN_W-1:0];
                REG_VAL_LOW:  bounds.val_low  = value[CHAN_W-1:0];
                REG_VAL_HIGH: bounds.val_high = value[CHAN_W-1:0];
                default: ;
            endcase
        endfunction

        // Hue is held as a fraction num/d, so each hue and saturation bound test is cross-multiplied.
        function res_word_t predict_mask(pixel_t px);
            longint b, g, r, mx, mn, d, num;
            longint hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;
            bit hue_ok, sat_ok, val_ok;
            res_word_t res;
            b = px.blue;
            g = px.green;
            r = px.red;
            hue_lo = bounds.hue_low;
            hue_hi = bounds.hue_high;
            sat_lo = bounds.sat_low;
            sat_hi = bounds.sat_high;
            val_lo = bounds.val_low;
            val_hi = bounds.val_high;
            mx = b;
            mn = b;
            if (g > mx) mx = g;
            if (r > mx) mx = r;
            if (g < mn) mn = g;
            if (r < mn) mn = r;
            d = mx - mn;

            // Red wins ties for the maximum, then green.
            if (d == 0)
            begin
                hue_ok = (hue_lo <= 0) && (0 <= hue_hi);
            end
            else
            begin
                if (mx == r)
                begin
                    num = 60 * (g - b);
                    if (num < 0) num += 360 * d;
                end
                else if (mx == g)
                begin
                    num = 120 * d + 60 * (b - r);
                end
                else
                begin
                    num = 240 * d + 60 * (r - g);
                end
                hue_ok = (hue_lo * d <= num) && (num <= hue_hi * d);
            end

            // A black pixel has zero saturation.
            if (mx == 0)
                sat_ok = (sat_lo <= 0) && (0 <= sat_hi);
            else
                sat_ok = (sat_lo * mx <= 255 * d) && (255 * d <= sat_hi * mx);

            val_ok = (val_lo <= mx) && (mx <= val_hi);

            res.kept = hue_ok && sat_ok && val_ok;
            res.pix  = res.kept ? px : {CHAN_MAX, CHAN_MAX, CHAN_MAX};
            return res;
        endfunction

        function void note_pixel(pixel_t px);
            owed_pixels.push_back(predict_mask(px));
        endfunction

        function void check_pixel(pixel_t got_pix, logic got_kept);
            res_word_t want;
            if (owed_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output word b=%0d g=%0d r=%0d kept=%0b",
                             got_pix.blue, got_pix.green, got_pix.red, got_kept);
                return;
            end
            want = owed_pixels.pop_front();
            checked++;
            if (want.kept) kept_seen++;
            if (want.pix.blue !== got_pix.blue || want.pix.green !== got_pix.green ||
                want.pix.red !== got_pix.red || want.kept !== got_kept)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: word %0d expected b=%0d g=%0d r=%0d kept=%0b, got b=%0d g=%0d r=%0d kept=%0b",
                             checked, want.pix.blue, want.pix.green, want.pix.red, want.kept,
                             got_pix.blue, got_pix.green, got_pix.red, got_kept);
            end
        endfunction

        function int unsigned pending();
            return owed_pixels.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata = '0;   // blue, green, red
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;        // out_blue, out_green, out_red
    logic                m_axis_tuser;        // kept
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    mask_scoreboard      mask_sb;
    bit                  src_idles;
    bit                  sink_idles;
    int unsigned         pixels_sent;
    int unsigned         bounds_loaded;

    hsv_range_pixel_mask_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d pixels still owed.", mask_sb.pending());
        $display("FAIL hsv_range_pixel_mask_unit");
        $finish;
    end

    // Setup cycle, then access cycle; the register is written at the access edge.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        mask_sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Picks one threshold setting and writes all six registers; raw mode also writes the spare addresses.
    task automatic load_bounds(input bounds_mode_t mode);
        logic [31:0] vals [0:5];
        int unsigned lo;
        int unsigned comp;
        int unsigned top;
        vals = '{0, HUE_FULL, 0, CHAN_MAX, 0, CHAN_MAX};
        case (mode)
            BOUNDS_BAND:
            begin
                lo = $urandom_range(0, HUE_FULL);
                vals[0] = lo;
                vals[1] = lo + $urandom_range(0, 200);
                if (vals[1] > HUE_FULL) vals[1] = HUE_FULL;
                for (int k = 2; k < 6; k += 2)
                begin
                    lo = $urandom_range(0, 200);
                    vals[k]   = lo;
                    vals[k+1] = lo + $urandom_range(0, 255);
                    if (vals[k+1] > CHAN_MAX) vals[k+1] = CHAN_MAX;
                end
            end
            BOUNDS_EXTREME:
            begin
                for (int k = 0; k < 6; k++)
                begin
                    top = (k < 2) ? (($urandom_range(0, 1) != 0) ? HUE_TOP : HUE_FULL)
                                  : CHAN_MAX;
                    vals[k] = ($urandom_range(0, 2) != 0) ? ((k % 2 != 0) ? top : 0)
                                                          : (($urandom_range(0, 1) != 0) ? top : 0);
                end
            end
            BOUNDS_RAW:
            begin
                for (int k = 0; k < 6; k++)
                    vals[k] = $urandom;
            end
            BOUNDS_INVERTED:
            begin
                comp = $urandom_range(0, 2);
                top  = (comp == 0) ? HUE_TOP : CHAN_MAX;
                lo   = $urandom_range(1, top);
                vals[2*comp]   = lo;
                vals[2*comp+1] = $urandom_range(0, lo - 1);
            end
            default: ;
        endcase
        for (int k = 0; k < 6; k++)
            apb_write(REG_ORDER[k], vals[k]);
        if (mode == BOUNDS_RAW)
        begin
            apb_write(REG_SPARE_A, $urandom);
            apb_write(REG_SPARE_B, $urandom);
        end
        bounds_loaded++;
    endtask

    // Grays, ties and near-wrap hues show up far more often than in plain random pixels.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        logic [23:0] raw;
        logic [7:0]  hi_v;
        logic [7:0]  lo_v;
        raw = 24'($urandom);
        px  = raw;
        case ($urandom_range(0, 7))
            0:
            begin
                hi_v = raw[7:0];
                px   = {hi_v, hi_v, hi_v};
            end
            1:
            begin
                hi_v = 8'($urandom_range(1, 255));
                lo_v = 8'($urandom_range(0, hi_v - 1));
                case ($urandom_range(0, 2))
                    0: px = {hi_v, hi_v, lo_v};
                    1: px = {lo_v, hi_v, hi_v};
                    default: px = {hi_v, lo_v, hi_v};
                endcase
            end
            2:
            begin
                for (int k = 0; k < 3; k++)
                    px[8*k +: 8] = ($urandom_range(0, 1) != 0) ? (8'hFF ^ raw[k]) : {7'd0, raw[k]};
            end
            3:
            begin
                px = {6'd0, raw[1:0], 6'd0, raw[3:2], 6'd0, raw[5:4]};
            end
            4:
            begin
                hi_v = 8'($urandom_range(8, 255));
                lo_v = 8'($urandom_range(0, hi_v - 8));
                px   = {hi_v, lo_v, lo_v + 8'($urandom_range(1, 7))};
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        gap = src_idles ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge clk); while (!s_axis_tready);
        mask_sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (mask_sb.pending() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Output side: random stalls before each word, checked at the accepting edge.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_idles ? $urandom_range(0, 15) : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            mask_sb.check_pixel(m_axis_tdata, m_axis_tuser);
        end
    end

    // Main sequence: corner pixels at reset thresholds, then random phases.
    initial
    begin
        int unsigned n_items;
        mask_sb       = new();
        pixels_sent   = 0;
        bounds_loaded = 0;
        src_idles     = 1'b1;
        sink_idles    = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER_PIXELS[k])
            send_pixel(CORNER_PIXELS[k]);
        wait_drained();

        for (int ph = 1; ph <= 15; ph++)
        begin
            load_bounds(bounds_mode_t'(ph % 5));
            if (ph % 4 == 1)
            begin
                src_idles  = 1'b0;
                sink_idles = 1'b0;
            end
            else
            begin
                src_idles  = ($urandom_range(0, 3) != 0);
                sink_idles = ($urandom_range(0, 3) != 0);
            end
            n_items = $urandom_range(110, 150);
            repeat (n_items)
                send_pixel(random_pixel());
            wait_drained();
        end

        $display("Sent %0d pixels over %0d threshold settings; %0d words checked, %0d kept.",
                 pixels_sent, bounds_loaded + 1, mask_sb.checked, mask_sb.kept_seen);
        $display("Mismatches: %0d, words still owed: %0d.", mask_sb.mismatches,
                 mask_sb.pending());
        if (mask_sb.mismatches == 0 && mask_sb.pending() == 0)
            $display("PASS hsv_range_pixel_mask_unit");
        else
            $display("FAIL hsv_range_pixel_mask_unit");
        $finish;
    end
endmodule
